@@ src/ost_pkg.sv @@
// ----------------------------------------------------------------------------
// ost_pkg: shared types and codes for the ordered set table
// Operation and status codes, the request and response words, cell control.
// ----------------------------------------------------------------------------
package ost_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
      logic               empty_res;
   } rsp_word_type;

   typedef struct packed {
      logic                      cmp;
      logic                      ins;
      logic                      rem;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

@@ src/ost_cell.sv @@
// ----------------------------------------------------------------------------
// ost_cell: one slot of the ordered set table
// Holds one element and its valid bit, compares against the request value,
// appends at the tail and shifts down from its upper neighbor on removal.
// ----------------------------------------------------------------------------
module ost_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  ost_pkg::cell_ctrl_type             ctrl,
   input  logic                               prev_valid,
   input  logic                               prev_seen,
   input  logic                               next_valid,
   input  logic signed [ost_pkg::VALUE_W-1:0] next_entry,
   output logic                               valid,
   output logic                               seen,
   output logic                               match,
   output logic signed [ost_pkg::VALUE_W-1:0] entry
);

   logic signed [ost_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                               valid_ff, valid_in;
   logic                               match_ff, match_in;

   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp) begin
         match_in = valid_ff && (entry_ff == ctrl.value);
      end
   end

   assign seen = prev_seen | match_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.rem && seen) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (ctrl.ins && !valid_ff && prev_valid) begin
         entry_in = ctrl.value;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign match = match_ff;
   assign entry = entry_ff;

endmodule

@@ src/ordered_set_table_top.sv @@
// ----------------------------------------------------------------------------
// ordered_set_table_top: ordered set of distinct values in a chain of cells
// Insert appends, remove closes the gap, lookup tests presence.
// ----------------------------------------------------------------------------
//  channel   ports                         direction  handshake
//  request   start, busy, req_word         in         start && !busy
//  response  rsp_strobe, rsp_word          out        rsp_strobe, one cycle
//
//  For each word the cells compare at the accept edge, then the
//  match chain resolves and the cells shift or append at the next edge,
//  which also registers the response. busy is high from the accept edge until that update.
//  Reset clears the valid bits and the count; the set starts empty.
//  The response cannot be stalled; a new word may be taken in the cycle
//  its predecessor's response is shown.
module ordered_set_table_top #(
   parameter int DEPTH = ost_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ost_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output ost_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                               accept;
   logic                               work_ff;
   logic [1:0]                         op_ff;
   logic signed [ost_pkg::VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]                   held_ff, held_in;
   logic                               rsp_strobe_ff;
   ost_pkg::rsp_word_type              rsp_word_ff, rsp_word_in;
   ost_pkg::cell_ctrl_type             ctrl;

   logic [DEPTH-1:0]                   valid;
   logic [DEPTH-1:0]                   seen;
   logic [DEPTH-1:0]                   match;
   logic signed [ost_pkg::VALUE_W-1:0] entry [DEPTH];

   logic any_match;
   logic full;

   assign accept    = start && !busy;
   assign busy      = work_ff;
   assign any_match = |match;
   assign full      = (held_ff == CNT_W'(DEPTH));

   always_comb begin
      ctrl.cmp   = accept;
      ctrl.value = work_ff ? value_ff : req_word.value;
      ctrl.ins   = work_ff && (op_ff == ost_pkg::OP_INSERT) && !any_match && !full;
      ctrl.rem   = work_ff && (op_ff == ost_pkg::OP_REMOVE) && any_match;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                               prev_valid, prev_seen, next_valid;
      logic signed [ost_pkg::VALUE_W-1:0] next_entry;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_seen  = 1'b0;
      end else begin : g_link
         assign prev_valid = valid[i-1];
         assign prev_seen  = seen[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_entry = '0;
      end else begin : g_next
         assign next_valid = valid[i+1];
         assign next_entry = entry[i+1];
      end

      ost_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_valid),
         .prev_seen  (prev_seen),
         .next_valid (next_valid),
         .next_entry (next_entry),
         .valid      (valid[i]),
         .seen       (seen[i]),
         .match      (match[i]),
         .entry      (entry[i])
      );
   end

   always_comb begin
      held_in            = held_ff;
      rsp_word_in.status = ost_pkg::ST_MISS;
      case (op_ff)
         ost_pkg::OP_INSERT: begin
            if (any_match) begin
               rsp_word_in.status = ost_pkg::ST_MISS;
            end else if (full) begin
               rsp_word_in.status = ost_pkg::ST_FULL;
            end else begin
               rsp_word_in.status = ost_pkg::ST_OK;
               held_in            = held_ff + CNT_W'(1);
            end
         end
         ost_pkg::OP_REMOVE: begin
            if (any_match) begin
               rsp_word_in.status = ost_pkg::ST_OK;
               held_in            = held_ff - CNT_W'(1);
            end
         end
         ost_pkg::OP_LOOKUP: begin
            rsp_word_in.status = any_match ? ost_pkg::ST_OK : ost_pkg::ST_MISS;
         end
         default: begin
            rsp_word_in.status = ost_pkg::ST_MISS;
         end
      endcase
      rsp_word_in.count     = ost_pkg::COUNT_W'(held_in);
      rsp_word_in.empty_res = (held_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff       <= 1'b0;
         held_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         work_ff       <= accept;
         rsp_strobe_ff <= work_ff;
         if (work_ff) begin
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_word.op;
         value_ff <= req_word.value;
      end
      if (work_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a preceding work cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not enter the work cycle");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      valid[0] == (held_ff != '0))
      else $error("head cell valid disagrees with count");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      busy |-> $onehot0(match))
      else $error("value matched in more than one cell");

endmodule

@@ tb/sv/tb_ordered_set_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_set_table_top: self-checking bench for the ordered set table
// Drives insert, remove and lookup words through the start/busy port, keeps
// its own copy of the set in insertion order, and compares every response
// word against the predicted status, count and empty flag.
// ----------------------------------------------------------------------------
module tb_ordered_set_table_top;

   localparam int          DEPTH     = ost_pkg::DEPTH_DEFAULT;
   localparam int          CLK_HALF  = 4;
   localparam int          MAX_CYCLE = 200000;
   localparam logic [1:0]  OP_SPARE  = 2'd3;
   localparam int          POOL_SIZE = 20;

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  start    = 1'b0;
   ost_pkg::req_word_type req_word = '0;
   logic                  busy;
   logic                  rsp_strobe;
   ost_pkg::rsp_word_type rsp_word;

   ost_pkg::req_word_type req_backlog[$];
   ost_pkg::rsp_word_type rsp_due[$];
   logic [31:0]           model_set[$];
   logic [31:0]           value_pool[POOL_SIZE];
   int                    idle_pct  = 18;
   int                    fail_cnt  = 0;
   int                    cycle_cnt = 0;

   ordered_set_table_top #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

   always #(CLK_HALF) clock = ~clock;

   // Applies one word to the shadow set and returns the response it should give.
   function automatic ost_pkg::rsp_word_type apply_set_op(ost_pkg::req_word_type w);
      ost_pkg::rsp_word_type r;
      int                    pos;
      pos = -1;
      foreach (model_set[i]) begin
         if (pos < 0 && model_set[i] == w.value) pos = i;
      end
      r.status = ost_pkg::ST_MISS;
      case (w.op)
         ost_pkg::OP_INSERT: begin
            if (pos >= 0) begin
               r.status = ost_pkg::ST_MISS;
            end else if (model_set.size() >= DEPTH) begin
               r.status = ost_pkg::ST_FULL;
            end else begin
               model_set.push_back(w.value);
               r.status = ost_pkg::ST_OK;
            end
         end
         ost_pkg::OP_REMOVE: begin
            if (pos >= 0) begin
               model_set.delete(pos);
               r.status = ost_pkg::ST_OK;
            end
         end
         ost_pkg::OP_LOOKUP: begin
            r.status = (pos >= 0) ? ost_pkg::ST_OK : ost_pkg::ST_MISS;
         end
         default: begin
            r.status = ost_pkg::ST_MISS;
         end
      endcase
      r.count     = ost_pkg::COUNT_W'(model_set.size());
      r.empty_res = (model_set.size() == 0);
      return r;
   endfunction

   task automatic push_req(logic [1:0] op, logic [31:0] value);
      ost_pkg::req_word_type w;
      w.op    = op;
      w.value = value;
      req_backlog.push_back(w);
   endtask

   task automatic queue_random(int n, int ins_pct, int rem_pct);
      int          r;
      logic [1:0]  op;
      logic [31:0] v;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 3) op = OP_SPARE;
         else if (r < 3 + ins_pct) op = ost_pkg::OP_INSERT;
         else if (r < 3 + ins_pct + rem_pct) op = ost_pkg::OP_REMOVE;
         else op = ost_pkg::OP_LOOKUP;
         if ($urandom_range(99) < 75) v = value_pool[$urandom_range(POOL_SIZE - 1)];
         else v = $urandom;
         push_req(op, v);
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || rsp_due.size() != 0) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin : drive_proc
      logic taken;
      taken = start && !busy;
      if (reset) begin
         start    <= 1'b0;
         req_word <= '0;
      end else begin
         if (taken) void'(req_backlog.pop_front());
         if (start && !taken) begin
            // hold the word until busy drops
         end else if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start    <= 1'b1;
            req_word <= req_backlog[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on accept, check on strobe
   always @(posedge clock) begin : check_proc
      ost_pkg::rsp_word_type exp_w;
      if (!reset) begin
         if (start && !busy) rsp_due.push_back(apply_set_op(req_word));
         if (rsp_strobe) begin
            if (rsp_due.size() == 0) begin
               $display("%0t: unexpected response word, actual %p", $time, rsp_word);
               fail_cnt++;
            end else begin
               exp_w = rsp_due.pop_front();
               if (rsp_word.status !== exp_w.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, exp_w.status, rsp_word.status);
                  fail_cnt++;
               end
               if (rsp_word.count !== exp_w.count) begin
                  $display("%0t: count mismatch, expected %0d actual %0d",
                           $time, exp_w.count, rsp_word.count);
                  fail_cnt++;
               end
               if (rsp_word.empty_res !== exp_w.empty_res) begin
                  $display("%0t: empty_res mismatch, expected %0d actual %0d",
                           $time, exp_w.empty_res, rsp_word.empty_res);
                  fail_cnt++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > MAX_CYCLE) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;

      // directed: empty set, extremes, duplicate, middle removal, fill, full store
      push_req(ost_pkg::OP_LOOKUP, 32'h0000_0005);
      push_req(ost_pkg::OP_REMOVE, 32'h0000_0005);
      push_req(OP_SPARE, 32'h0000_0005);
      push_req(ost_pkg::OP_INSERT, 32'h8000_0000);
      push_req(ost_pkg::OP_INSERT, 32'h7fff_ffff);
      push_req(ost_pkg::OP_INSERT, 32'h0000_0000);
      push_req(ost_pkg::OP_INSERT, 32'hffff_ffff);
      push_req(ost_pkg::OP_INSERT, 32'h7fff_ffff);
      push_req(ost_pkg::OP_LOOKUP, 32'h7fff_ffff);
      push_req(ost_pkg::OP_REMOVE, 32'h7fff_ffff);
      push_req(ost_pkg::OP_LOOKUP, 32'h7fff_ffff);
      push_req(OP_SPARE, 32'h0000_0000);
      for (int k = 0; k < DEPTH - 3; k++) push_req(ost_pkg::OP_INSERT, 32'h0001_0000 + k);
      push_req(ost_pkg::OP_INSERT, 32'h5a5a_5a5a);
      push_req(ost_pkg::OP_INSERT, 32'h0000_0000);
      push_req(ost_pkg::OP_REMOVE, 32'h8000_0000);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 18 : (ph == 1) ? 76 : 0;
         queue_random(70, 65, 15);
         queue_random(65, 35, 35);
         queue_random(65, 15, 65);
         wait_drained();
      end

      repeat (6) @(negedge clock);
      if (fail_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/ost_pkg.sv
src/ost_cell.sv
src/ordered_set_table_top.sv
tb/sv/tb_ordered_set_table_top.sv
